>>> hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// shared types, command codes and the beep pattern rom of the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    localparam int NUM_PATTERNS = 5;
    localparam int ROW_LEN      = 16;
    localparam int DUR_W        = 7;
    localparam int STEP_W       = 4;
    localparam int SOUND_W      = 3;
    localparam int KIND_W       = 2;
    localparam int NOW_W        = 32;

    typedef logic [DUR_W-1:0]   dur_t;
    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [SOUND_W-1:0] sound_t;
    typedef logic [KIND_W-1:0]  kind_t;

    // command kinds
    localparam kind_t KIND_SERVICE = 2'd0;
    localparam kind_t KIND_PLAY    = 2'd1;
    localparam kind_t KIND_STOP    = 2'd2;

    // sound codes
    localparam sound_t SOUND_CLICK = 3'd0;

    typedef dur_t rom_row_t [ROW_LEN];
    typedef rom_row_t rom_t [NUM_PATTERNS];

    // zero-terminated duration lists in ms
    localparam rom_t BEEP_ROM = '{
        '{7'd25, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
          7'd0,  7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd22, 7'd28, 7'd28, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
          7'd0,  7'd0,  7'd0,  7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd35, 7'd35, 7'd35, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
          7'd0,  7'd0,  7'd0,  7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd90, 7'd55, 7'd30, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
          7'd0,  7'd0,  7'd0,  7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd35, 7'd35, 7'd35, 7'd35, 7'd70, 7'd60, 7'd35, 7'd35,
          7'd110, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0}
    };

    // unknown patterns fall back to click
    function automatic dur_t rom_read(input sound_t pat, input step_t idx);
        dur_t d;
        d = BEEP_ROM[0][idx];
        case (pat)
            3'd1:    d = BEEP_ROM[1][idx];
            3'd2:    d = BEEP_ROM[2][idx];
            3'd3:    d = BEEP_ROM[3][idx];
            3'd4:    d = BEEP_ROM[4][idx];
            default: d = BEEP_ROM[0][idx];
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bps_cmd_if.sv
// ----------------------------------------------------------------------------
// bps_cmd_if
// command channel: kind, sound code and millisecond timestamp
// ----------------------------------------------------------------------------
`default_nettype none

interface bps_cmd_if;
    import bps_pkg::*;

    logic                valid;
    logic                ready;
    kind_t               kind;
    sound_t              sound;
    logic [NOW_W-1:0]    now_ms;

    modport source (output valid, output kind, output sound, output now_ms, input ready);
    modport sink   (input valid, input kind, input sound, input now_ms, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bps_res_if.sv
// ----------------------------------------------------------------------------
// bps_res_if
// result channel: pin level, tone state and busy flag
// ----------------------------------------------------------------------------
`default_nettype none

interface bps_res_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic tone_on;
    logic busy_res;

    modport source (output valid, output pin_level, output tone_on, output busy_res,
                    input ready);
    modport sink   (input valid, input pin_level, input tone_on, input busy_res,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bps_cfg_if.sv
// ----------------------------------------------------------------------------
// bps_cfg_if
// configuration write channel for the pin polarity register
// ----------------------------------------------------------------------------
`default_nettype none

interface bps_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/buzzer_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// plays fixed on/off beep patterns from a rom, driven by timestamped commands
// ----------------------------------------------------------------------------
// usage:
//   cmd carries one command per transaction: play (with a sound code), stop
//   or service (time check). each command yields exactly one transaction on
//   res with the pin level, tone state and busy flag after that command.
//   cfg writes the pin polarity (1 = pin high while the tone sounds); it is
//   always ready and should only be written while no result is pending.
// throughput and timing:
//   one command per cycle sustained while res.ready keeps draining the
//   result register. the pattern rom lookup, the signed deadline compare
//   and the deadline add are combinational up to the result register; the
//   result shows up in the cycle after the command transaction.
// stall:
//   the result register holds while res.ready is low; cmd stays ready as long
//   as the result register is empty or being drained in the same cycle.
// reset:
//   idle, tone off, click pattern selected, deadline zero, polarity active
//   high, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module buzzer_pattern_sequencer
    import bps_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  wire       clk,
    input  wire       rst_n,
    bps_cmd_if.sink   cmd,
    bps_res_if.source res,
    bps_cfg_if.sink   cfg
);

    // playback state
    logic                 playing_reg,  playing_next;
    sound_t               pattern_reg,  pattern_next;
    step_t                step_reg,     step_next;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next;
    logic                 sounding_reg, sounding_next;

    // polarity register
    logic                 active_high_reg;

    // result register
    logic                 res_valid_reg;
    logic                 pin_reg;
    logic                 tone_reg;
    logic                 busy_reg;

    logic                 cmd_accept;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] diff;
    step_t                step_inc;
    sound_t               play_pat;
    dur_t                 play_dur;
    dur_t                 svc_dur;

    // accept a new command whenever the result slot frees up this cycle
    assign cmd.ready  = !res_valid_reg || res.ready;
    assign cmd_accept = cmd.valid && cmd.ready;
    assign cfg.ready  = 1'b1;

    // time is taken modulo 2^TIME_BITS
    assign now_t    = TIME_BITS'(cmd.now_ms);
    assign diff     = now_t - deadline_reg;
    assign step_inc = step_reg + step_t'(1);
    assign play_pat = (cmd.sound < sound_t'(NUM_PATTERNS)) ? cmd.sound : SOUND_CLICK;
    assign play_dur = rom_read(play_pat, '0);
    assign svc_dur  = rom_read(pattern_reg, step_inc);

    always_comb
    begin
        playing_next  = playing_reg;
        pattern_next  = pattern_reg;
        step_next     = step_reg;
        deadline_next = deadline_reg;
        sounding_next = sounding_reg;
        case (cmd.kind)
            KIND_PLAY:
            begin
                // restart with the new pattern, tone on for the first step
                pattern_next  = play_pat;
                step_next     = '0;
                playing_next  = 1'b1;
                sounding_next = 1'b1;
                deadline_next = now_t + TIME_BITS'(play_dur);
            end
            KIND_STOP:
            begin
                playing_next  = 1'b0;
                pattern_next  = SOUND_CLICK;
                step_next     = '0;
                sounding_next = 1'b0;
            end
            KIND_SERVICE:
            begin
                // deadline reached when now - deadline is non-negative
                if (playing_reg && !diff[TIME_BITS-1])
                begin
                    if (svc_dur == '0)
                    begin
                        // end of pattern list
                        playing_next  = 1'b0;
                        pattern_next  = SOUND_CLICK;
                        step_next     = '0;
                        sounding_next = 1'b0;
                    end
                    else
                    begin
                        step_next     = step_inc;
                        sounding_next = !step_inc[0];
                        deadline_next = now_t + TIME_BITS'(svc_dur);
                    end
                end
            end
            default:
            begin
                // undefined kind leaves the state alone
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg     <= 1'b0;
            pattern_reg     <= SOUND_CLICK;
            step_reg        <= '0;
            deadline_reg    <= '0;
            sounding_reg    <= 1'b0;
            active_high_reg <= 1'b1;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                active_high_reg <= cfg.data;
            end
            if (cmd_accept)
            begin
                playing_reg   <= playing_next;
                pattern_reg   <= pattern_next;
                step_reg      <= step_next;
                deadline_reg  <= deadline_next;
                sounding_reg  <= sounding_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, polarity applied at the time of the command
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            pin_reg  <= active_high_reg ? sounding_next : !sounding_next;
            tone_reg <= sounding_next;
            busy_reg <= playing_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.pin_level = pin_reg;
    assign res.tone_on   = tone_reg;
    assign res.busy_res  = busy_reg;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the buzzer pattern sequencer: a scoreboard class
// tracks playback state, deadline and pin polarity for every command
// transaction and checks each result transaction in order; directed corner
// cases come first, then randomized play/service sequences with idling,
// a long result-side hold-off and drain pauses between polarity changes
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    // kind code with no meaning, must leave the state alone
    localparam kind_t KIND_UNUSED = 2'd3;
    // sound codes at or above this play the click pattern
    localparam int    KNOWN_SOUNDS = 5;
    // result-side hold-off length, long enough to back up the command port
    localparam int    HOLD_CYCLES = 300;
    // cycles without any transaction before the run is declared hung
    localparam int    WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic pin_level;
        logic tone_on;
        logic busy_res;
    } beep_outputs_t;

    // ------------------------------------------------------------------------
    // scoreboard: tracks playback state and holds the expected outputs
    // ------------------------------------------------------------------------
    class beep_scoreboard;
        logic          polarity;
        logic          playing;
        sound_t        pattern_sel;
        step_t         step;
        logic [31:0]   deadline;
        logic          sounding;
        beep_outputs_t expected_q[$];
        int unsigned   commands;
        int unsigned   results;
        int unsigned   errors;
        int unsigned   advances;
        int unsigned   completions;

        function new();
            polarity    = 1'b1;
            playing     = 1'b0;
            pattern_sel = SOUND_CLICK;
            step        = '0;
            deadline    = '0;
            sounding    = 1'b0;
            commands    = 0;
            results     = 0;
            errors      = 0;
            advances    = 0;
            completions = 0;
        endfunction

        // duration table, zero ends a pattern
        function int unsigned beep_ms(sound_t pat, step_t idx);
            int unsigned ms;
            ms = 0;
            case (pat)
                3'd1:
                    case (idx)
                        4'd0:       ms = 22;
                        4'd1, 4'd2: ms = 28;
                        default:    ms = 0;
                    endcase
                3'd2:
                    if (idx < 3) ms = 35;
                3'd3:
                    case (idx)
                        4'd0:    ms = 90;
                        4'd1:    ms = 55;
                        4'd2:    ms = 30;
                        default: ms = 0;
                    endcase
                3'd4:
                    case (idx)
                        4'd4:    ms = 70;
                        4'd5:    ms = 60;
                        4'd8:    ms = 110;
                        4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15:
                                 ms = 0;
                        default: ms = 35;
                    endcase
                default:
                    if (idx == 0) ms = 25;
            endcase
            return ms;
        endfunction

        function void set_polarity(logic level);
            polarity = level;
        endfunction

        function void halt();
            playing     = 1'b0;
            pattern_sel = SOUND_CLICK;
            step        = '0;
            sounding    = 1'b0;
        endfunction

        // one accepted command transaction
        function void note_command(kind_t kind, sound_t sound, logic [31:0] now);
            logic [31:0]   diff;
            int unsigned   ms;
            beep_outputs_t want;
            commands++;
            case (kind)
                KIND_PLAY:
                begin
                    pattern_sel = (sound < KNOWN_SOUNDS) ? sound : SOUND_CLICK;
                    step        = '0;
                    playing     = 1'b1;
                    sounding    = 1'b1;
                    deadline    = now + beep_ms(pattern_sel, step);
                end
                KIND_STOP:
                    halt();
                KIND_SERVICE:
                    if (playing)
                    begin
                        diff = now - deadline;
                        if (!diff[31])
                        begin
                            advances++;
                            step = step + 1'b1;
                            ms   = beep_ms(pattern_sel, step);
                            if (ms == 0)
                            begin
                                completions++;
                                halt();
                            end
                            else
                            begin
                                sounding = ~step[0];
                                deadline = now + ms;
                            end
                        end
                    end
                default:
                    ;
            endcase
            want.pin_level = polarity ? sounding : ~sounding;
            want.tone_on   = sounding;
            want.busy_res  = playing;
            expected_q.push_back(want);
        endfunction

        // one accepted result transaction
        function void check_result(logic pin, logic tone, logic busy);
            beep_outputs_t want;
            results++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: pin_level %b tone_on %b busy_res %b",
                         $time, pin, tone, busy);
                return;
            end
            want = expected_q.pop_front();
            if (pin !== want.pin_level)
            begin
                errors++;
                $display("%0t: pin_level mismatch: expected %b actual %b",
                         $time, want.pin_level, pin);
            end
            if (tone !== want.tone_on)
            begin
                errors++;
                $display("%0t: tone_on mismatch: expected %b actual %b",
                         $time, want.tone_on, tone);
            end
            if (busy !== want.busy_res)
            begin
                errors++;
                $display("%0t: busy_res mismatch: expected %b actual %b",
                         $time, want.busy_res, busy);
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    bps_cmd_if cmd_ch ();
    bps_res_if res_ch ();
    bps_cfg_if cfg_ch ();

    buzzer_pattern_sequencer #(
        .TIME_BITS (32)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    beep_scoreboard sb;

    // bench control
    logic        steady;      // no idling on either side while set
    logic        hold_req;    // asks the receiver for one long hold-off
    int          hold_left;
    bit          burst;       // sender offers back to back, used during the hold-off
    int unsigned quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // receiver: random ready, a long hold-off on request, steady stretches
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_req)
        begin
            // hold-off is counted here, the sender keeps going meanwhile
            hold_req     <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (steady)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(99) >= 24);
    end

    // every result transaction goes straight to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            sb.check_result(res_ch.pin_level, res_ch.tone_on, res_ch.busy_res);
    end

    // watchdog: any transaction on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n ||
            (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog: no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.outstanding());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks, all entered and left right after a rising edge
    // ------------------------------------------------------------------------

    // offer one command, optionally after a random gap, and note it on acceptance
    task automatic send_cmd(input kind_t kind, input sound_t sound, input logic [31:0] now);
        int unsigned gap;
        if (!steady && !burst && $urandom_range(99) < 24)
        begin
            gap = ($urandom_range(19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.kind   <= kind;
        cmd_ch.sound  <= sound;
        cmd_ch.now_ms <= now;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        sb.note_command(kind, sound, now);
    endtask

    // stop offering and wait until every expected result has been taken
    task automatic wait_results_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.outstanding() != 0);
        @(posedge clk);
    endtask

    // polarity write, only ever issued with nothing in flight
    task automatic write_polarity(input logic level);
        // one command per result, so this wait covers the result register
        repeat (2) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= level;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.set_polarity(level);
        cfg_ch.valid <= 1'b0;
    endtask

    // play a random pattern and service it with times mostly near the deadline
    task automatic play_sequence();
        logic [31:0] t;
        int unsigned services;
        int unsigned pick;
        // a quarter of sequences start just below the wrap of the time counter
        t = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom();
        send_cmd(KIND_PLAY, $urandom_range(7), t);
        services = $urandom_range(3, 24);
        repeat (services)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                // one before, at or one after the deadline
                t = sb.deadline + $urandom_range(2) - 32'd1;
                send_cmd(KIND_SERVICE, $urandom_range(7), t);
            end
            else if (pick < 86)
            begin
                t = t + $urandom_range(40);
                send_cmd(KIND_SERVICE, $urandom_range(7), t);
            end
            else if (pick < 92)
            begin
                // far jump, either side of the deadline
                t = t + $urandom();
                send_cmd(KIND_SERVICE, $urandom_range(7), t);
            end
            else if (pick < 95)
                send_cmd(KIND_STOP, $urandom_range(7), t);
            else if (pick < 97)
                send_cmd(KIND_UNUSED, $urandom_range(7), t);
            else
                send_cmd(KIND_PLAY, $urandom_range(7), t);
        end
    endtask

    // one random phase, optionally with the long result-side hold-off halfway
    task automatic run_phase(input int unsigned items, input bit with_holdoff);
        int unsigned first;
        bit          held;
        first = sb.commands;
        held  = 1'b0;
        while (sb.commands - first < items)
        begin
            if (with_holdoff && !held && sb.commands - first > items / 2)
            begin
                held     = 1'b1;
                hold_req <= 1'b1;
                burst    = 1'b1;
                repeat (3) play_sequence();
                burst    = 1'b0;
            end
            if ($urandom_range(99) < 85)
                play_sequence();
            else
                send_cmd($urandom_range(3), $urandom_range(7), $urandom());
            if ($urandom_range(49) == 0)
                wait_results_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        burst         = 1'b0;
        quiet_cycles  = 0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.kind   = KIND_SERVICE;
        cmd_ch.sound  = SOUND_CLICK;
        cmd_ch.now_ms = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_polarity(1'b1);

        // directed: idle service, unknown kind, deadline across the counter wrap
        send_cmd(KIND_SERVICE, SOUND_CLICK, 32'd0);
        send_cmd(KIND_UNUSED, 3'd7, 32'hFFFF_FFFF);
        send_cmd(KIND_PLAY, SOUND_CLICK, 32'hFFFF_FFF0);       // deadline wraps to 9
        send_cmd(KIND_SERVICE, SOUND_CLICK, 32'hFFFF_FFFF);    // still before it
        send_cmd(KIND_SERVICE, SOUND_CLICK, 32'd9);            // exactly on it, click ends
        // page: one short of the deadline, then on it
        send_cmd(KIND_PLAY, 3'd1, 32'd100);
        send_cmd(KIND_SERVICE, SOUND_CLICK, 32'd121);
        send_cmd(KIND_SERVICE, SOUND_CLICK, 32'd122);
        // play while playing, then the signed compare at its two limits
        send_cmd(KIND_PLAY, 3'd4, 32'd200);                   // deadline 235
        send_cmd(KIND_SERVICE, SOUND_CLICK, 32'd235 + 32'h8000_0000);
        send_cmd(KIND_SERVICE, SOUND_CLICK, 32'd235 + 32'h7FFF_FFFF);
        send_cmd(KIND_STOP, SOUND_CLICK, 32'd0);
        send_cmd(KIND_SERVICE, SOUND_CLICK, 32'd1000);         // idle after stop
        // unknown sound codes fall back to click, then the remaining patterns
        send_cmd(KIND_PLAY, 3'd5, 32'd2000);
        send_cmd(KIND_PLAY, 3'd6, 32'd3000);
        send_cmd(KIND_PLAY, 3'd7, 32'd4000);
        send_cmd(KIND_SERVICE, SOUND_CLICK, 32'd4025);
        send_cmd(KIND_PLAY, 3'd2, 32'd5000);
        send_cmd(KIND_PLAY, 3'd3, 32'd6000);
        send_cmd(KIND_SERVICE, SOUND_CLICK, 32'd6090);
        send_cmd(KIND_STOP, 3'd7, 32'hFFFF_FFFF);
        wait_results_drained();

        // inverted polarity, with the long hold-off in the middle
        write_polarity(1'b0);
        run_phase(650, 1'b1);
        wait_results_drained();

        // active high again, starting with a stretch free of idling
        write_polarity(1'b1);
        steady <= 1'b1;
        run_phase(300, 1'b0);
        steady <= 1'b0;
        run_phase(350, 1'b0);
        wait_results_drained();

        write_polarity(1'b0);
        run_phase(650, 1'b0);
        wait_results_drained();

        // wait on so a stray result would still be caught
        repeat (5) @(posedge clk);

        $display("covered %0d commands and %0d results, %0d pattern steps,",
                 sb.commands, sb.results, sb.advances);
        $display("%0d patterns to the end, both polarities, unknown sounds and kinds,",
                 sb.completions);
        $display("wrapped deadlines, stalls and drains");
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d errors, %0d results never arrived", sb.errors, sb.outstanding());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
